/* rtl/cau_pkg.sv */
// Shared constants, types and helper functions for the complex arithmetic unit.
package cau_pkg;

  // Operand format
  localparam int DW   = 32;          // data width
  localparam int FB   = 16;          // fraction bits
  localparam int PW   = 2 * DW;      // product width
  localparam int SW   = PW + 2;      // sum of products width
  localparam int QW   = DW + 1;      // quotient bits kept by the divider
  localparam int DENW = PW;          // |b|^2 width (|a|^2 for reciprocal)
  localparam int DVW  = PW + 2 * FB; // scaled dividend width

  localparam logic signed [SW-1:0] SAT_HI = {{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}};
  localparam logic signed [SW-1:0] RND    = {{(SW-FB){1'b0}}, {FB{1'b1}}};
  localparam logic [DW-1:0]        MAX_V  = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0]        MIN_V  = {1'b1, {(DW-1){1'b0}}};
  localparam logic [QW-1:0]        Q_LIM  = {2'b01, {(DW-1){1'b0}}};

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_MUL   = 3'd2,
    MODE_DIV   = 3'd3,
    MODE_RECIP = 3'd4,
    MODE_CONJ  = 3'd5,
    MODE_DOT   = 3'd6,
    MODE_CROSS = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

  // One result part on its way through the divider stages
  typedef struct packed {
    logic            neg;
    logic            pre_ovf;
    logic [DENW-1:0] rem;
    logic [QW-1:0]   dlo;
    logic [QW-1:0]   q;
    logic [DW-1:0]   val;
    logic            ovf;
  } lane_t;

  typedef struct packed {
    logic            is_div;
    logic            div0;
    logic [DENW-1:0] den;
    lane_t           re;
    lane_t           im;
  } dstage_t;

  // Arithmetic shift right by FB, truncating toward zero
  function automatic logic signed [SW-1:0] shr_tz(logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = v[SW-1] ? (v + RND) : v;
    return t >>> FB;
  endfunction

  // Saturate a wide value into a lane's val/ovf
  function automatic lane_t sat_lane(lane_t l, logic signed [SW-1:0] v);
    lane_t o;
    o = l;
    if (v > SAT_HI) begin
      o.val = MAX_V;
      o.ovf = 1'b1;
    end else if (v < SAT_LO) begin
      o.val = MIN_V;
      o.ovf = 1'b1;
    end else begin
      o.val = v[DW-1:0];
      o.ovf = 1'b0;
    end
    return o;
  endfunction

  // Set up the long division of (|num| << shift) by den
  function automatic lane_t div_init(lane_t l, logic signed [SW-1:0] num, logic sh2,
                                     logic [DENW-1:0] den);
    lane_t          o;
    logic [SW-1:0]  mag;
    logic [DVW-1:0] dvd;
    logic [DVW-QW-1:0] hi;
    o   = l;
    mag = num[SW-1] ? (~num + 1'b1) : num;
    dvd = sh2 ? (DVW'(mag) << (2 * FB)) : (DVW'(mag) << FB);
    hi  = dvd[DVW-1:QW];
    o.neg     = num[SW-1];
    o.pre_ovf = DENW'(hi) >= den;
    o.rem     = DENW'(hi);
    o.dlo     = dvd[QW-1:0];
    o.q       = '0;
    return o;
  endfunction

  // One restoring division step
  function automatic lane_t div_step(lane_t l, logic [DENW-1:0] den);
    lane_t       o;
    logic [DENW:0] r;
    logic [DENW:0] t;
    o     = l;
    r     = {l.rem, l.dlo[QW-1]};
    t     = r - {1'b0, den};
    o.dlo = l.dlo << 1;
    if (r >= {1'b0, den}) begin
      o.rem = t[DENW-1:0];
      o.q   = {l.q[QW-2:0], 1'b1};
    end else begin
      o.rem = r[DENW-1:0];
      o.q   = {l.q[QW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dstage_t dstage_step(dstage_t s);
    dstage_t o;
    o    = s;
    o.re = div_step(s.re, s.den);
    o.im = div_step(s.im, s.den);
    return o;
  endfunction

  // Signed, saturated quotient of a finished lane
  function automatic lane_t div_final(lane_t l);
    lane_t         o;
    logic [QW-1:0] nq;
    o  = l;
    nq = ~l.q + 1'b1;
    if (l.neg) begin
      if (l.pre_ovf || (l.q > Q_LIM)) begin
        o.val = MIN_V;
        o.ovf = 1'b1;
      end else begin
        o.val = nq[DW-1:0];
        o.ovf = 1'b0;
      end
    end else begin
      if (l.pre_ovf || (l.q >= Q_LIM)) begin
        o.val = MAX_V;
        o.ovf = 1'b1;
      end else begin
        o.val = l.q[DW-1:0];
        o.ovf = 1'b0;
      end
    end
    return o;
  endfunction

endpackage

/* rtl/complex_arithmetic_unit_top.sv */
// Complex arithmetic unit: fully pipelined add/sub/mul/div/recip/conj/dot/cross.
// Every mode passes through the same pipeline to the result.
// Throughput: one transaction per cycle while the output is not stalled; the 33-stage
// restoring divider (one quotient bit per stage) sets the depth.
// A stalled output freezes the whole pipeline; in_stall follows it.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
module complex_arithmetic_unit_top
  import cau_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           mode,
  input  logic signed [DW-1:0] a_re,
  input  logic signed [DW-1:0] a_im,
  input  logic signed [DW-1:0] b_re,
  input  logic signed [DW-1:0] b_im,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [DW-1:0] res_re,
  output logic signed [DW-1:0] res_im,
  output logic [1:0]           status
);

  logic adv;

  // Stage 0: input register
  logic                 s0_v;
  mode_t                s0_mode;
  logic signed [DW-1:0] s0_ar, s0_ai, s0_br, s0_bi;

  // Stage 1: products
  logic                 s1_v;
  mode_t                s1_mode;
  logic signed [DW-1:0] s1_ar, s1_ai, s1_br, s1_bi;
  logic signed [PW-1:0] s1_p0, s1_p1, s1_p2, s1_p3, s1_p4, s1_p5;

  // Stage 2: sums
  logic                 s2_v;
  mode_t                s2_mode;
  logic signed [SW-1:0] s2_re, s2_im;
  logic [DENW-1:0]      s2_den;
  logic signed [SW-1:0] re_sum, im_sum;
  logic [SW-1:0]        den_sum;

  // Stage 3 and divider stages
  logic    dv [0:QW];
  dstage_t dst [0:QW];
  dstage_t d_init;
  lane_t   fin_re, fin_im;
  logic signed [DW-1:0] sq_re, sq_im;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
    end else if (adv) begin
      s0_v <= in_valid;
    end
    if (adv) begin
      s0_mode <= mode_t'(mode);
      s0_ar   <= a_re;
      s0_ai   <= a_im;
      s0_br   <= b_re;
      s0_bi   <= b_im;
    end
  end

  // Six signed multipliers; the squares use a for reciprocal, else b
  assign sq_re = (s0_mode == MODE_RECIP) ? s0_ar : s0_br;
  assign sq_im = (s0_mode == MODE_RECIP) ? s0_ai : s0_bi;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (adv) begin
      s1_v <= s0_v;
    end
    if (adv) begin
      s1_mode <= s0_mode;
      s1_ar   <= s0_ar;
      s1_ai   <= s0_ai;
      s1_br   <= s0_br;
      s1_bi   <= s0_bi;
      s1_p0   <= s0_ar * s0_br;
      s1_p1   <= s0_ai * s0_bi;
      s1_p2   <= s0_ar * s0_bi;
      s1_p3   <= s0_ai * s0_br;
      s1_p4   <= sq_re * sq_re;
      s1_p5   <= sq_im * sq_im;
    end
  end

  // Combine products per mode
  always_comb begin
    den_sum = SW'(s1_p4) + SW'(s1_p5);
    unique case (s1_mode)
      MODE_ADD: begin
        re_sum = SW'(s1_ar) + SW'(s1_br);
        im_sum = SW'(s1_ai) + SW'(s1_bi);
      end
      MODE_SUB: begin
        re_sum = SW'(s1_ar) - SW'(s1_br);
        im_sum = SW'(s1_ai) - SW'(s1_bi);
      end
      MODE_MUL: begin
        re_sum = SW'(s1_p0) - SW'(s1_p1);
        im_sum = SW'(s1_p2) + SW'(s1_p3);
      end
      MODE_DIV: begin
        re_sum = SW'(s1_p0) + SW'(s1_p1);
        im_sum = SW'(s1_p3) - SW'(s1_p2);
      end
      MODE_RECIP: begin
        re_sum = SW'(s1_ar);
        im_sum = -SW'(s1_ai);
      end
      MODE_CONJ: begin
        re_sum = SW'(s1_ar);
        im_sum = -SW'(s1_ai);
      end
      MODE_DOT: begin
        re_sum = SW'(s1_p0) + SW'(s1_p1);
        im_sum = '0;
      end
      MODE_CROSS: begin
        re_sum = SW'(s1_p2) - SW'(s1_p3);
        im_sum = '0;
      end
      default: begin
        re_sum = '0;
        im_sum = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (adv) begin
      s2_v <= s1_v;
    end
    if (adv) begin
      s2_mode <= s1_mode;
      s2_re   <= re_sum;
      s2_im   <= im_sum;
      s2_den  <= den_sum[DENW-1:0];
    end
  end

  // Scale and saturate direct results; set up the dividers
  always_comb begin
    logic signed [SW-1:0] vre, vim;
    logic scaled, sh2;
    scaled = (s2_mode == MODE_MUL) || (s2_mode == MODE_DOT) || (s2_mode == MODE_CROSS);
    sh2    = (s2_mode == MODE_RECIP);
    vre    = scaled ? shr_tz(s2_re) : s2_re;
    vim    = scaled ? shr_tz(s2_im) : s2_im;
    d_init        = '0;
    d_init.is_div = (s2_mode == MODE_DIV) || (s2_mode == MODE_RECIP);
    d_init.div0   = d_init.is_div && (s2_den == '0);
    d_init.den    = s2_den;
    d_init.re     = sat_lane(div_init(d_init.re, s2_re, sh2, s2_den), vre);
    d_init.im     = sat_lane(div_init(d_init.im, s2_im, sh2, s2_den), vim);
  end

  // Divider pipeline: setup register, then one quotient bit per stage
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= s2_v;
    end
    if (adv) begin
      dst[0] <= d_init;
    end
    for (int i = 0; i < QW; i++) begin
      if (rst) begin
        dv[i+1] <= 1'b0;
      end else if (adv) begin
        dv[i+1] <= dv[i];
      end
      if (adv) begin
        dst[i+1] <= dstage_step(dst[i]);
      end
    end
  end

  // Final selection and output register
  assign fin_re = dst[QW].is_div ? div_final(dst[QW].re) : dst[QW].re;
  assign fin_im = dst[QW].is_div ? div_final(dst[QW].im) : dst[QW].im;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv[QW];
    end
    if (adv) begin
      if (dst[QW].div0) begin
        res_re <= MAX_V;
        res_im <= MAX_V;
        status <= ST_DIV0;
      end else begin
        res_re <= fin_re.val;
        res_im <= fin_im.val;
        status <= (fin_re.ovf || fin_im.ovf) ? ST_OVF : ST_OK;
      end
    end
  end

endmodule

/* rtl/cau_checker.sv */
// Port-level checker for the complex arithmetic unit, bound to the top level.
module cau_checker
  import cau_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input logic signed [DW-1:0] res_re,
  input logic signed [DW-1:0] res_im,
  input logic [1:0]           status
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(res_re) && $stable(res_im)
      && $stable(status))
    else $error("stalled result changed");

  // Input is held off exactly while a result waits
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("in_stall does not follow output stall");

  // Divide by zero gives the largest value in both parts
  a_div0: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_DIV0) |-> (res_re == MAX_V) && (res_im == MAX_V))
    else $error("divide by zero result not saturated");

  // No undefined status code
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK) || (status == ST_OVF) || (status == ST_DIV0))
    else $error("bad status code");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (.*);
